// File: rtl/cflts_pkg.sv
// ----------------------------------------------------------------------------
// cflts_pkg
// Shared widths, register indexes, status codes and types for the CFL
// time step core.
// ----------------------------------------------------------------------------
package cflts_pkg;

  localparam int DATA_W    = 32;
  localparam int CFL_W     = 17;
  localparam int GAMMA_W   = 19;
  localparam int LEVEL_W   = 5;
  localparam int STATUS_W  = 2;
  localparam int SPEED_W   = 33;
  localparam int SQ_W      = 64;
  localparam int ROOT_W    = 32;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COURANT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAMMA   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAP     = 2'd2;

  localparam logic [CFL_W-1:0]   COURANT_RST = 17'd52429;
  localparam logic [GAMMA_W-1:0] GAMMA_RST   = 19'd109227;
  localparam logic [DATA_W-1:0]  CAP_RST     = 32'hFFFF_FFFF;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_NORMAL = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CAP    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZDEN   = 2'd2;

  // classified cell word passed from front to back
  typedef struct packed {
    logic [DATA_W-1:0]  ax;
    logic [DATA_W-1:0]  ay;
    logic [DATA_W-1:0]  az;
    logic [DATA_W-1:0]  pressure;
    logic [DATA_W-1:0]  density;
    logic [LEVEL_W-1:0] level;
    logic               last_cell;
    logic               dzero;
  } cell_t;

  typedef enum logic [2:0] {
    B_IDLE, B_MUL, B_VSQRT, B_DIV, B_ASQRT, B_FOLD, B_TDIV, B_OUT
  } back_state_t;

  function automatic logic [DATA_W-1:0] abs32(input logic [DATA_W-1:0] v);
    abs32 = v[DATA_W-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

// File: rtl/cflts_front.sv
// ----------------------------------------------------------------------------
// cflts_front
// Accepts cell words, takes velocity magnitudes and flags zero density.
// ----------------------------------------------------------------------------
module cflts_front import cflts_pkg::*; (
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] vel_x,
  input  logic signed [DATA_W-1:0] vel_y,
  input  logic signed [DATA_W-1:0] vel_z,
  input  logic [DATA_W-1:0]        pressure,
  input  logic [DATA_W-1:0]        density,
  input  logic [LEVEL_W-1:0]       level,
  input  logic                     last_cell,
  output logic                     push,
  output cell_t                    push_word,
  input  logic                     full
);

  // accept whenever the queue has room
  assign in_ready = !full;
  assign push     = in_valid && !full;

  // classify the cell
  always_comb begin
    push_word.ax        = abs32(vel_x);
    push_word.ay        = abs32(vel_y);
    push_word.az        = abs32(vel_z);
    push_word.pressure  = pressure;
    push_word.density   = density;
    push_word.level     = level;
    push_word.last_cell = last_cell;
    push_word.dzero     = (density == '0);
  end

endmodule

// File: rtl/cflts_queue.sv
// ----------------------------------------------------------------------------
// cflts_queue
// Two-entry queue of classified cell words between front and back.
// ----------------------------------------------------------------------------
module cflts_queue import cflts_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  cell_t push_word,
  output logic  full,
  input  logic  pop,
  output cell_t pop_word,
  output logic  empty
);

  cell_t       mem [2];
  logic        wptr;
  logic        rptr;
  logic [1:0]  count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_word = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_word;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/cflts_back.sv
// ----------------------------------------------------------------------------
// cflts_back
// Per-cell signal speed, running maximum and time step, using a shared
// restoring divider and a shared bit-pair square root unit.
// ----------------------------------------------------------------------------
module cflts_back import cflts_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                empty,
  input  cell_t               pop_word,
  output logic                pop,
  input  logic [CFL_W-1:0]    courant_factor,
  input  logic [GAMMA_W-1:0]  adiabatic_index,
  input  logic [DATA_W-1:0]   step_cap,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [DATA_W-1:0]   time_step,
  output logic [STATUS_W-1:0] status
);

  localparam int NUM_W = GAMMA_W + DATA_W;
  localparam int DVW   = (NUM_W + FRAC_BITS > SQ_W) ? NUM_W + FRAC_BITS : SQ_W + 1;
  localparam int DSW   = SPEED_W + 2;
  localparam int CNT_W = $clog2(DVW + 1);

  back_state_t state, state_next;

  cell_t                item;
  logic [CNT_W-1:0]     cnt;
  logic [SQ_W-1:0]      prod;
  logic [SQ_W-1:0]      acc;
  logic [NUM_W-1:0]     num;
  logic [ROOT_W-1:0]    va;
  logic [ROOT_W-1:0]    aa;
  logic [SPEED_W-1:0]   max_signal_speed;
  logic                 zero_density_seen;
  logic [DATA_W-1:0]    res_step;
  logic [STATUS_W-1:0]  res_status;

  // divider registers
  logic [DVW-1:0]       dvd;
  logic [DSW-1:0]       dvs;
  logic [DSW-1:0]       drem;
  // square root registers
  logic [SQ_W-1:0]      sx;
  logic [ROOT_W-1:0]    root;
  logic [ROOT_W+1:0]    srem;

  // divider step
  logic [DSW:0]         div_t;
  logic                 div_ge;
  logic [DSW-1:0]       drem_next;
  logic [DVW-1:0]       dvd_next;
  always_comb begin
    div_t     = {drem, dvd[DVW-1]};
    div_ge    = (div_t >= {1'b0, dvs});
    drem_next = div_ge ? DSW'(div_t - {1'b0, dvs}) : DSW'(div_t);
    dvd_next  = {dvd[DVW-2:0], div_ge};
  end

  // square root step
  logic [ROOT_W+3:0]    sq_r;
  logic [ROOT_W+3:0]    sq_trial;
  logic                 sq_ge;
  logic [ROOT_W+1:0]    srem_next;
  logic [ROOT_W-1:0]    root_next;
  always_comb begin
    sq_r      = {srem, sx[SQ_W-1 -: 2]};
    sq_trial  = {2'b00, root, 2'b01};
    sq_ge     = (sq_r >= sq_trial);
    srem_next = sq_ge ? (ROOT_W+2)'(sq_r - sq_trial) : (ROOT_W+2)'(sq_r);
    root_next = {root[ROOT_W-2:0], sq_ge};
  end

  // squares operand select
  logic [DATA_W-1:0] sq_op;
  always_comb begin
    case (cnt[1:0])
      2'd0:    sq_op = item.ax;
      2'd1:    sq_op = item.ay;
      default: sq_op = item.az;
    endcase
  end

  // fold and step arithmetic
  logic [SPEED_W-1:0] speed;
  logic [SPEED_W-1:0] max_new;
  logic [DVW-1:0]     t_shift;
  logic [DATA_W-1:0]  t_sat;
  logic [SQ_W-1:0]    q_sat;
  always_comb begin
    speed   = SPEED_W'(va) + SPEED_W'(aa);
    max_new = (speed > max_signal_speed) ? speed : max_signal_speed;
    t_shift = dvd_next >> item.level;
    t_sat   = (t_shift > DVW'({DATA_W{1'b1}})) ? {DATA_W{1'b1}} : t_shift[DATA_W-1:0];
    q_sat   = (|dvd_next[DVW-1:SQ_W]) ? {SQ_W{1'b1}} : dvd_next[SQ_W-1:0];
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  logic last_iter_sq;
  logic last_iter_div;
  assign last_iter_sq  = (cnt == CNT_W'(ROOT_W - 1));
  assign last_iter_div = (cnt == CNT_W'(DVW - 1));

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    case (state)
      B_IDLE: begin
        if (!empty) begin
          pop        = 1'b1;
          state_next = B_MUL;
        end
      end
      B_MUL:   if (cnt == CNT_W'(3)) state_next = B_VSQRT;
      B_VSQRT: if (last_iter_sq) state_next = item.dzero ? B_FOLD : B_DIV;
      B_DIV:   if (last_iter_div) state_next = B_ASQRT;
      B_ASQRT: if (last_iter_sq) state_next = B_FOLD;
      B_FOLD: begin
        if (!item.last_cell)      state_next = B_IDLE;
        else if (max_new == '0)   state_next = B_OUT;
        else                      state_next = B_TDIV;
      end
      B_TDIV:  if (last_iter_div) state_next = B_OUT;
      B_OUT:   if (!out_valid || out_ready) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // running maximum, flag and result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      max_signal_speed  <= '0;
      zero_density_seen <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (state == B_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready)                 out_valid <= 1'b0;
      if (state == B_FOLD) begin
        if (item.last_cell) begin
          max_signal_speed  <= '0;
          zero_density_seen <= 1'b0;
        end else begin
          max_signal_speed  <= max_new;
          zero_density_seen <= zero_density_seen | item.dzero;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        item <= pop_word;
        cnt  <= '0;
      end
      B_MUL: begin
        prod <= SQ_W'(sq_op) * SQ_W'(sq_op);
        if (cnt == '0) begin
          acc <= '0;
          num <= NUM_W'(adiabatic_index) * NUM_W'(item.pressure);
        end else begin
          acc <= acc + prod;
        end
        if (cnt == CNT_W'(3)) begin
          sx   <= acc + prod;
          root <= '0;
          srem <= '0;
          cnt  <= '0;
        end else begin
          cnt  <= cnt + 1'b1;
        end
      end
      B_VSQRT: begin
        sx   <= sx << 2;
        root <= root_next;
        srem <= srem_next;
        if (last_iter_sq) begin
          va   <= root_next;
          aa   <= {ROOT_W{1'b1}};
          dvd  <= DVW'(num) << FRAC_BITS;
          dvs  <= DSW'(item.density);
          drem <= '0;
          cnt  <= '0;
        end else begin
          cnt  <= cnt + 1'b1;
        end
      end
      B_DIV: begin
        dvd  <= dvd_next;
        drem <= drem_next;
        if (last_iter_div) begin
          sx   <= q_sat;
          root <= '0;
          srem <= '0;
          cnt  <= '0;
        end else begin
          cnt  <= cnt + 1'b1;
        end
      end
      B_ASQRT: begin
        sx   <= sx << 2;
        root <= root_next;
        srem <= srem_next;
        cnt  <= cnt + 1'b1;
        if (last_iter_sq) aa <= root_next;
      end
      B_FOLD: begin
        cnt        <= '0;
        dvd        <= DVW'(courant_factor) << FRAC_BITS;
        dvs        <= DSW'(max_new) + DSW'({max_new, 1'b0});
        drem       <= '0;
        res_step   <= step_cap;
        res_status <= (zero_density_seen || item.dzero) ? ST_ZDEN :
                      (max_new == '0) ? ST_CAP : ST_NORMAL;
      end
      B_TDIV: begin
        dvd  <= dvd_next;
        drem <= drem_next;
        cnt  <= cnt + 1'b1;
        if (last_iter_div && t_sat < step_cap) res_step <= t_sat;
      end
      B_OUT: begin
        if (!out_valid || out_ready) begin
          time_step <= res_step;
          status    <= res_status;
        end
      end
      default: cnt <= '0;
    endcase
  end

endmodule

// File: rtl/cfl_hydro_timestep_core.sv
// ----------------------------------------------------------------------------
// cfl_hydro_timestep_core
// Streams grid cells, tracks the largest signal speed and emits the CFL
// time step on the last cell of a run.
// ----------------------------------------------------------------------------
// In the back end a cell uses the shared one-bit-a-cycle divider and the
// shared two-bits-a-cycle square root (dividend width DVW = 51 + FRAC_BITS,
// at least 65); a zero density cell skips the divide and second root. A
// last cell adds the step divide, unless the maximum speed is zero, plus
// any result stall. The front queue holds two cells. Synchronous reset
// restores register defaults and clears the maximum, the flag, the queue
// and the output valid.
module cfl_hydro_timestep_core import cflts_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] vel_x,
  input  logic signed [DATA_W-1:0] vel_y,
  input  logic signed [DATA_W-1:0] vel_z,
  input  logic [DATA_W-1:0]        pressure,
  input  logic [DATA_W-1:0]        density,
  input  logic [LEVEL_W-1:0]       level,
  input  logic                     last_cell,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [DATA_W-1:0]        time_step,
  output logic [STATUS_W-1:0]      status,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data
);

  logic [CFL_W-1:0]   courant_factor;
  logic [GAMMA_W-1:0] adiabatic_index;
  logic [DATA_W-1:0]  step_cap;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      courant_factor  <= COURANT_RST;
      adiabatic_index <= GAMMA_RST;
      step_cap        <= CAP_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COURANT: courant_factor  <= cfg_data[CFL_W-1:0];
        REG_GAMMA:   adiabatic_index <= cfg_data[GAMMA_W-1:0];
        REG_CAP:     step_cap        <= cfg_data;
        default:     step_cap        <= step_cap;
      endcase
    end
  end

  logic  push;
  cell_t push_word;
  logic  full;
  logic  pop;
  cell_t pop_word;
  logic  empty;

  cflts_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .vel_x     (vel_x),
    .vel_y     (vel_y),
    .vel_z     (vel_z),
    .pressure  (pressure),
    .density   (density),
    .level     (level),
    .last_cell (last_cell),
    .push      (push),
    .push_word (push_word),
    .full      (full)
  );

  cflts_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .full      (full),
    .pop       (pop),
    .pop_word  (pop_word),
    .empty     (empty)
  );

  cflts_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk             (clk),
    .rst             (rst),
    .empty           (empty),
    .pop_word        (pop_word),
    .pop             (pop),
    .courant_factor  (courant_factor),
    .adiabatic_index (adiabatic_index),
    .step_cap        (step_cap),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .time_step       (time_step),
    .status          (status)
  );

endmodule
